// ----- hw/rtl/i2cmb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmb_pkg: shared types and codes of the I2C master byte engine
// Command codes, bus line selects and the engine state record used by the
// step logic and the top level.
// ----------------------------------------------------------------------------
package i2cmb_pkg;

  // Command codes carried on the func field.
  localparam logic [2:0] CMD_IDLE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_READ_ACK  = 3'd3;
  localparam logic [2:0] CMD_READ_NACK = 3'd4;
  localparam logic [2:0] CMD_STOP      = 3'd5;

  // Which bus line a phase changes.
  localparam logic LINE_SCL = 1'b0;
  localparam logic LINE_SDA = 1'b1;

  // Speed mode codes; the unused code behaves like the fastest mode.
  localparam logic [1:0] SPEED_STD  = 2'd0;
  localparam logic [1:0] SPEED_MID  = 2'd1;
  localparam logic [1:0] SPEED_FAST = 2'd2;

  // Complete engine state between two ticks.
  typedef struct packed {
    logic [2:0] cmd;
    logic [4:0] phase;
    logic [1:0] tick;
    logic [7:0] shreg;
    logic       ack;
    logic       scl;
    logic       sda;
    logic [7:0] rx_hold;
  } i2cmb_state_t;

  // One result item as produced by the step logic.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] rx_byte;
  } i2cmb_res_t;

  // Description of one phase of a command.
  typedef struct packed {
    logic line;
    logic val;
    logic sample;
    logic last;
  } i2cmb_desc_t;

endpackage

// ----- hw/rtl/i2cmb_step.sv -----
// ----------------------------------------------------------------------------
// i2cmb_step: one-tick next-state logic of the I2C master byte engine
// Takes the current engine state and one tick's inputs and returns the state
// after the tick together with the result item of that tick.
// ----------------------------------------------------------------------------
module i2cmb_step
  import i2cmb_pkg::*;
(
  input  i2cmb_state_t state_cur,
  input  logic [1:0]   speed_mode,
  input  logic [2:0]   func,
  input  logic [7:0]   tx_byte,
  input  logic         sda_in,
  output i2cmb_state_t state_nxt,
  output i2cmb_res_t   res
);

  // Phase length in ticks for the current speed mode.
  function automatic logic [1:0] phase_len(input logic [1:0] mode);
    logic [1:0] len;
    case (mode)
      SPEED_STD: len = 2'd3;
      SPEED_MID: len = 2'd2;
      default:   len = 2'd1;
    endcase
    return len;
  endfunction

  // Line, level, sampling and end marker of phase idx of command cmd.
  function automatic i2cmb_desc_t describe(input logic [2:0] cmd,
                                           input logic [4:0] idx,
                                           input logic [7:0] shreg);
    i2cmb_desc_t d;
    logic [8:0]  prod;
    logic [2:0]  bit_no;
    logic [4:0]  rem5;
    d = '0;
    // Bit number is idx / 3, done as a multiply by 11/32 (exact for idx < 24).
    prod   = {4'd0, idx} * 9'd11;
    bit_no = prod[7:5];
    rem5   = idx - ({2'b00, bit_no} * 5'd3);
    case (cmd)
      CMD_START: begin
        if (idx == 5'd0) begin
          d.line = LINE_SCL; d.val = 1'b1;
        end else if (idx == 5'd1) begin
          d.line = LINE_SDA; d.val = 1'b1;
        end else begin
          d.line = LINE_SDA; d.val = 1'b0; d.last = 1'b1;
        end
      end
      CMD_STOP: begin
        if (idx == 5'd0) begin
          d.line = LINE_SCL; d.val = 1'b0;
        end else if (idx == 5'd1) begin
          d.line = LINE_SDA; d.val = 1'b0;
        end else if (idx == 5'd2) begin
          d.line = LINE_SCL; d.val = 1'b1;
        end else begin
          d.line = LINE_SDA; d.val = 1'b1; d.last = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (idx < 5'd24) begin
          if (rem5[1:0] == 2'd0) begin
            d.line = LINE_SCL; d.val = 1'b0;
          end else if (rem5[1:0] == 2'd1) begin
            d.line = LINE_SDA; d.val = shreg[3'd7 - bit_no];
          end else begin
            d.line = LINE_SCL; d.val = 1'b1;
          end
        end else if (idx == 5'd24) begin
          d.line = LINE_SCL; d.val = 1'b0;
        end else if (idx == 5'd25) begin
          d.line = LINE_SDA; d.val = 1'b1;
        end else if (idx == 5'd26) begin
          d.line = LINE_SCL; d.val = 1'b1; d.sample = 1'b1;
        end else begin
          d.line = LINE_SCL; d.val = 1'b0; d.last = 1'b1;
        end
      end
      default: begin
        // Read with ACK or NACK.
        if (idx == 5'd0) begin
          d.line = LINE_SCL; d.val = 1'b0;
        end else if (idx == 5'd1) begin
          d.line = LINE_SDA; d.val = 1'b1;
        end else if (idx < 5'd18) begin
          d.line = LINE_SCL;
          if (!idx[0]) begin
            d.val = 1'b0; d.sample = 1'b1;
          end else begin
            d.val = 1'b1;
          end
        end else if (idx == 5'd18) begin
          d.line = LINE_SCL; d.val = 1'b0;
        end else if (idx == 5'd19) begin
          d.line = LINE_SDA; d.val = (cmd == CMD_READ_NACK);
        end else begin
          d.line = LINE_SCL; d.val = 1'b1; d.last = 1'b1;
        end
      end
    endcase
    return d;
  endfunction

  i2cmb_state_t st;
  i2cmb_desc_t  desc;
  logic         busy;
  logic         done;
  logic [1:0]   len;
  logic         phase_end;

  always_comb begin
    st        = state_cur;
    busy      = 1'b0;
    done      = 1'b0;
    len       = phase_len(speed_mode);
    desc      = '0;
    phase_end = 1'b0;

    // A command is taken only while idle; unused codes act as a plain tick.
    if (state_cur.cmd == CMD_IDLE && func inside {[CMD_START:CMD_STOP]}) begin
      st.cmd   = func;
      st.phase = '0;
      st.tick  = '0;
      if (func == CMD_WRITE) begin
        st.shreg = tx_byte;
      end else if (func == CMD_READ_ACK || func == CMD_READ_NACK) begin
        st.shreg = '0;
      end
    end

    if (st.cmd != CMD_IDLE) begin
      busy = 1'b1;
      desc = describe(st.cmd, st.phase, st.shreg);
      if (st.tick == 2'd0) begin
        if (desc.line == LINE_SCL) begin
          st.scl = desc.val;
        end else begin
          st.sda = desc.val;
        end
      end
      phase_end = (({1'b0, st.tick} + 3'd1) >= {1'b0, len});
      if (phase_end) begin
        if (desc.sample) begin
          if (st.cmd == CMD_WRITE) begin
            st.ack = ~sda_in;
          end else begin
            st.shreg = {st.shreg[6:0], sda_in};
          end
        end
        st.tick = '0;
        if (desc.last) begin
          done = 1'b1;
          if (st.cmd == CMD_READ_ACK || st.cmd == CMD_READ_NACK) begin
            st.rx_hold = st.shreg;
          end
          st.cmd   = CMD_IDLE;
          st.phase = '0;
        end else begin
          st.phase = st.phase + 5'd1;
        end
      end else begin
        st.tick = st.tick + 2'd1;
      end
    end

    state_nxt    = st;
    res.scl_out  = st.scl;
    res.sda_out  = st.sda;
    res.busy_res = busy;
    res.done_res = done;
    res.ack_seen = st.ack;
    res.rx_byte  = st.rx_hold;
  end

endmodule

// ----- hw/rtl/i2c_master_byte_engine_core.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core: tick-driven I2C master byte engine
// Steps SCL and SDA through start, write byte, read byte and stop sequences,
// one timer tick per input transfer, and reports one result per tick.
// ----------------------------------------------------------------------------
// Usage:
// Every input transfer is one microsecond tick of the bus timer. It carries a
// command code (in_func), the byte to send (in_tx_byte) and the sampled SDA
// level (in_sda_in). A command is taken only on a tick where the engine is
// idle; while busy the code is ignored and the tick just advances the bus.
// Each tick yields exactly one result transfer with the SCL/SDA drive levels,
// busy and done flags, the last write ACK and the last received byte.
// The result of a tick is registered in the output register in the cycle
// after its transfer. Throughput is one tick per clock cycle, limited only
// by the single output register: a new tick is taken whenever that
// register is empty or being drained in the same cycle.
// When the receiver stalls, in_stall rises in the same cycle and the held
// result stays unchanged until it is taken; no tick is lost or repeated.
// cfg_wr_en writes speed_mode (phase length 3, 2 or 1 ticks) and is meant
// for idle periods only. Synchronous reset returns the engine to idle with
// both lines released, clears ack and received byte and empties the output.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_core
  import i2cmb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // Configuration port.
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  // Tick input channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_func,
  input  logic [7:0] in_tx_byte,
  input  logic       in_sda_in,
  // Result channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_ack_seen,
  output logic [7:0] out_rx_byte
);

  localparam i2cmb_state_t STATE_RESET = '{
    cmd:     CMD_IDLE,
    phase:   5'd0,
    tick:    2'd0,
    shreg:   8'd0,
    ack:     1'b0,
    scl:     1'b1,
    sda:     1'b1,
    rx_hold: 8'd0
  };

  logic [1:0]   speed_mode_r;
  i2cmb_state_t state_r;
  i2cmb_state_t state_nxt;
  i2cmb_res_t   res;
  i2cmb_res_t   res_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         in_xfer;

  // The output register is the only buffer: a tick can enter whenever the
  // register is free or its content leaves in this cycle.
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  i2cmb_step u_step (
    .state_cur  (state_r),
    .speed_mode (speed_mode_r),
    .func       (in_func),
    .tx_byte    (in_tx_byte),
    .sda_in     (in_sda_in),
    .state_nxt  (state_nxt),
    .res        (res)
  );

  assign out_valid_nxt = in_xfer | (out_valid_r & out_stall);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_mode_r <= SPEED_STD;
    end else if (cfg_wr_en) begin
      speed_mode_r <= cfg_wr_data;
    end
  end

  // Engine state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; no reset needed, qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_scl_out  = res_r.scl_out;
  assign out_sda_out  = res_r.sda_out;
  assign out_busy_res = res_r.busy_res;
  assign out_done_res = res_r.done_res;
  assign out_ack_seen = res_r.ack_seen;
  assign out_rx_byte  = res_r.rx_byte;

`ifndef SYNTHESIS
  // An idle engine always sits at the first tick of the first phase.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.cmd == CMD_IDLE) |-> (state_r.phase == 5'd0 && state_r.tick == 2'd0))
    else $error("idle engine with nonzero phase or tick");

  // The tick counter never reaches three.
  a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.tick != 2'd3)
    else $error("tick counter out of range");

  // A done tick leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && res.done_res) |=> (state_r.cmd == CMD_IDLE))
    else $error("engine not idle after done");

  // Done is only ever reported on a busy tick.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.done_res) |-> res_r.busy_res)
    else $error("done without busy");

  // A stalled result holds off the next tick so nothing is overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !in_xfer)
    else $error("tick accepted over a stalled result");
`endif

endmodule
